// ----- src/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
   localparam int WordBitsDefault = 32;
   localparam int MagBits = 33;
   localparam int ProdBits = 66;

   typedef enum logic [2:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_CMP = 3'd4
   } kind_type;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_DIV0 = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL1,
      CMD_MUL2,
      CMD_SUM,
      CMD_CHECK,
      CMD_DIV_START,
      CMD_DIV_STEP,
      CMD_GCD_SWAP,
      CMD_QUOT_NUM,
      CMD_QUOT_DEN,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rem_zero;
      logic need_gcd;
      logic is_cmp;
   } status_type;
endpackage
`default_nettype wire

// ----- src/rau_if.sv -----
`default_nettype none
interface rau_if #(parameter int PayloadBits = 1);
   logic valid;
   logic ready;
   logic [PayloadBits-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/rau_ctrl.sv -----
`default_nettype none
module rau_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rau_pkg::status_type  stat,
   output rau_pkg::cmd_type          cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_SUM, S_CHECK, S_DSTART, S_DSTEP, S_SWAP,
      S_QN_START, S_QN_STEP, S_QN_DONE, S_QD_START, S_QD_STEP, S_QD_DONE,
      S_OUT
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd = rau_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE:     if (req_valid) cmd = rau_pkg::CMD_LOAD;
         S_MUL1:     cmd = rau_pkg::CMD_MUL1;
         S_MUL2:     cmd = rau_pkg::CMD_MUL2;
         S_SUM:      cmd = rau_pkg::CMD_SUM;
         S_CHECK:    cmd = rau_pkg::CMD_CHECK;
         S_DSTART, S_QN_START, S_QD_START: cmd = rau_pkg::CMD_DIV_START;
         S_DSTEP, S_QN_STEP, S_QD_STEP:    cmd = rau_pkg::CMD_DIV_STEP;
         S_SWAP:     cmd = rau_pkg::CMD_GCD_SWAP;
         S_QN_DONE:  cmd = rau_pkg::CMD_QUOT_NUM;
         S_QD_DONE:  cmd = rau_pkg::CMD_QUOT_DEN;
         S_OUT:      cmd = rau_pkg::CMD_FINISH;
         default:    cmd = rau_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_MUL1;
            S_MUL1:   state_ff <= stat.is_cmp ? S_OUT : S_MUL2;
            S_MUL2:   state_ff <= S_SUM;
            S_SUM:    state_ff <= S_CHECK;
            S_CHECK:  state_ff <= stat.need_gcd ? S_DSTART : S_OUT;
            S_DSTART: state_ff <= S_DSTEP;
            S_DSTEP:  if (stat.div_done) state_ff <= S_SWAP;
            S_SWAP:   state_ff <= stat.rem_zero ? S_QN_START : S_DSTART;
            S_QN_START: state_ff <= S_QN_STEP;
            S_QN_STEP:  if (stat.div_done) state_ff <= S_QN_DONE;
            S_QN_DONE:  state_ff <= S_QD_START;
            S_QD_START: state_ff <= S_QD_STEP;
            S_QD_STEP:  if (stat.div_done) state_ff <= S_QD_DONE;
            S_QD_DONE:  state_ff <= S_OUT;
            S_OUT:      if (rsp_ready) state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- src/rau_datapath.sv -----
`default_nettype none
module rau_datapath #(
   parameter int WORD_BITS = rau_pkg::WordBitsDefault
) (
   input  wire logic                clock,
   input  wire rau_pkg::cmd_type    cmd,
   input  wire logic [2:0]          kind,
   input  wire logic signed [31:0]  a_num,
   input  wire logic [30:0]         a_den,
   input  wire logic signed [31:0]  b_num,
   input  wire logic [30:0]         b_den,
   output rau_pkg::status_type      stat,
   output logic signed [31:0]       res_num,
   output logic [30:0]              res_den,
   output logic                     is_equal,
   output logic [1:0]               status
);
   localparam int PB = rau_pkg::ProdBits;
   localparam int MB = rau_pkg::MagBits;
   localparam int CntBits = $clog2(MB + 1);
   localparam logic signed [PB-1:0] Hi = (PB'(1) <<< (WORD_BITS - 1)) - PB'(1);
   localparam logic signed [PB-1:0] Lo = -Hi - PB'(1);

   logic [2:0]              kind_ff;
   logic signed [32:0]      an_ff, bn_ff, ad_ff, bd_ff;
   logic signed [PB-1:0]    p1_ff, p2_ff, n_ff, d_ff;
   logic                    eq_ff;
   logic                    nneg_ff;
   logic [MB-1:0]           gp_ff, gq_ff;  // gcd pair
   logic [MB-1:0]           dvd_ff, dvs_ff, quo_ff, rem_ff;
   logic [CntBits-1:0]      cnt_ff;
   logic [MB-1:0]           nmag_ff, dmag_ff;
   logic signed [31:0]      rn_ff;
   logic [30:0]             rd_ff;
   logic [1:0]              st_ff;
   logic                    range_bad;
   logic                    gcd_go;
   logic                    cmp_kind;
   logic [MB:0]             trial;
   logic signed [PB-1:0]    nn, dn, mul_a, mul_b, mul_p;
   logic signed [PB:0]      qn_s;

   // shared multiplier operand selection
   always_comb begin
      mul_a = PB'(an_ff);
      mul_b = PB'(bd_ff);
      if (cmd == rau_pkg::CMD_MUL2) begin
         mul_a = (kind_ff == rau_pkg::KIND_MUL) ? PB'(an_ff) : PB'(bn_ff);
         mul_b = (kind_ff == rau_pkg::KIND_MUL) ? PB'(bn_ff) : PB'(ad_ff);
      end else if (kind_ff == rau_pkg::KIND_MUL || kind_ff == rau_pkg::KIND_SUB
                   || kind_ff == rau_pkg::KIND_ADD) begin
         mul_a = PB'(ad_ff);
         mul_b = PB'(bd_ff);
      end else begin
         mul_a = PB'(ad_ff);
         mul_b = PB'(bn_ff);
      end
   end
   assign mul_p = PB'(mul_a * mul_b);

   assign nn = -n_ff;
   assign dn = -d_ff;
   assign trial = {rem_ff, dvd_ff[MB-1]} - {1'b0, dvs_ff};
   assign qn_s = nneg_ff ? -(PB+1)'(quo_ff) : (PB+1)'(quo_ff);

   // unreduced pair checks for the check state, kind flag for the mul1 state
   assign range_bad = (n_ff < Lo) || (n_ff > Hi) || (d_ff < Lo) || (d_ff > Hi);
   assign gcd_go = !range_bad && (d_ff != '0) && (n_ff != '0);
   assign cmp_kind = (kind_ff == rau_pkg::KIND_CMP) || (kind_ff > rau_pkg::KIND_CMP);

   assign stat = '{div_done: (cnt_ff == '0),
                   rem_zero: (rem_ff == '0),
                   need_gcd: gcd_go,
                   is_cmp:   cmp_kind};

   always_ff @(posedge clock) begin
      unique case (cmd)
         rau_pkg::CMD_LOAD: begin
            kind_ff <= kind;
            an_ff <= 33'(a_num);
            bn_ff <= 33'(b_num);
            ad_ff <= {2'b00, a_den};
            bd_ff <= {2'b00, b_den};
            eq_ff <= (a_num == b_num) && (a_den == b_den);
         end
         rau_pkg::CMD_MUL1: begin
            // first product: denominator (ad*bd, or ad*bn for divide)
            p1_ff <= mul_p;
            rn_ff <= '0;
            rd_ff <= '0;
            st_ff <= rau_pkg::STATUS_OK;
            if (kind_ff == rau_pkg::KIND_DIV) begin
               p2_ff <= PB'(an_ff) * PB'(bd_ff);
            end else begin
               p2_ff <= PB'(an_ff) * PB'(bd_ff);
            end
         end
         rau_pkg::CMD_MUL2: begin
            n_ff <= mul_p;
         end
         rau_pkg::CMD_SUM: begin
            unique case (kind_ff)
               rau_pkg::KIND_ADD: begin n_ff <= p2_ff + n_ff; d_ff <= p1_ff; end
               rau_pkg::KIND_SUB: begin n_ff <= p2_ff - n_ff; d_ff <= p1_ff; end
               rau_pkg::KIND_MUL: begin d_ff <= p1_ff; end
               default:           begin n_ff <= p2_ff; d_ff <= p1_ff; end
            endcase
         end
         rau_pkg::CMD_CHECK: begin
            if (range_bad) begin
               st_ff <= rau_pkg::STATUS_RANGE;
            end else if (d_ff == '0) begin
               st_ff <= rau_pkg::STATUS_DIV0;
            end else if (n_ff == '0) begin
               rd_ff <= 31'd1;
            end else begin
               // sign flip folded into magnitudes
               nneg_ff <= (n_ff < 0) ^ (d_ff < 0);
               nmag_ff <= (n_ff < 0) ? MB'(nn) : MB'(n_ff);
               dmag_ff <= (d_ff < 0) ? MB'(dn) : MB'(d_ff);
               gp_ff <= (n_ff < 0) ? MB'(nn) : MB'(n_ff);
               gq_ff <= (d_ff < 0) ? MB'(dn) : MB'(d_ff);
            end
         end
         rau_pkg::CMD_DIV_START: begin
            // divisor: gcd step uses gq, quotients use the finished gcd in gp
            if (gq_ff != '0) begin
               dvd_ff <= gp_ff;
               dvs_ff <= gq_ff;
            end else begin
               dvd_ff <= (cnt_ff == CntBits'(1)) ? dmag_ff : nmag_ff;
               dvs_ff <= gp_ff;
            end
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CntBits'(MB);
         end
         rau_pkg::CMD_DIV_STEP: begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - CntBits'(1);
               dvd_ff <= {dvd_ff[MB-2:0], 1'b0};
               if (!trial[MB]) begin
                  rem_ff <= trial[MB-1:0];
                  quo_ff <= {quo_ff[MB-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[MB-2:0], dvd_ff[MB-1]};
                  quo_ff <= {quo_ff[MB-2:0], 1'b0};
               end
            end
         end
         rau_pkg::CMD_GCD_SWAP: begin
            gp_ff <= gq_ff;
            gq_ff <= rem_ff;
            cnt_ff <= '0;
         end
         rau_pkg::CMD_QUOT_NUM: begin
            if (qn_s < (PB+1)'(Lo) || qn_s > (PB+1)'(Hi)) st_ff <= rau_pkg::STATUS_RANGE;
            rn_ff <= 32'(qn_s);
            cnt_ff <= CntBits'(1);
         end
         rau_pkg::CMD_QUOT_DEN: begin
            if (st_ff == rau_pkg::STATUS_RANGE || PB'(quo_ff) > Hi) begin
               st_ff <= rau_pkg::STATUS_RANGE;
               rn_ff <= '0;
               rd_ff <= '0;
            end else begin
               rd_ff <= 31'(quo_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign res_num = stat.is_cmp ? '0 : rn_ff;
   assign res_den = stat.is_cmp ? '0 : rd_ff;
   assign is_equal = (kind_ff == rau_pkg::KIND_CMP) & eq_ff;
   assign status = stat.is_cmp ? rau_pkg::STATUS_OK : st_ff;
endmodule
`default_nettype wire

// ----- src/rational_arith_unit_core.sv -----
`default_nettype none
// rational arithmetic unit: add, sub, mul, div, compare of reduced fractions
// compare and unused kinds respond after the first product; range error, zero divisor
// or zero numerator skip the reduction; reduction runs gcd division steps, then divides
// both by the gcd; one request at a time, next taken in the cycle after the response
// the 33-step restoring divider, shared by gcd and final quotients, sets the rate
// reset: synchronous active high, returns the controller to idle, no clearing pass
module rational_arith_unit_core #(
   parameter int WORD_BITS = rau_pkg::WordBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   rau_if.sink      req,
   rau_if.source    rsp
);
   // request payload: kind, a_num, a_den, b_num, b_den (kind in the top bits)
   // response payload: res_num, res_den, is_equal, status
   rau_pkg::cmd_type    cmd;
   rau_pkg::status_type stat;
   logic signed [31:0]  res_num;
   logic [30:0]         res_den;
   logic                is_equal;
   logic [1:0]          status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .kind     (req.payload[128:126]),
      .a_num    (req.payload[125:94]),
      .a_den    (req.payload[93:63]),
      .b_num    (req.payload[62:31]),
      .b_den    (req.payload[30:0]),
      .stat     (stat),
      .res_num  (res_num),
      .res_den  (res_den),
      .is_equal (is_equal),
      .status   (status)
   );

   // response packing
   assign rsp.payload = {res_num, res_den, is_equal, status};
endmodule
`default_nettype wire
